@@ src/rme_pkg.sv @@
package rme_pkg;

    // cordic accumulator width: 18 integer bits plus 16 fraction bits, with margin
    localparam int unsigned CW = 36;

    localparam logic [31:0] ZQ_POS = 32'h4000_0000;
    localparam logic [31:0] ZQ_NEG = 32'hC000_0000;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r10;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
    } t_mat;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0: v = 32'd536870912;
            5'd1: v = 32'd316933406;
            5'd2: v = 32'd167458907;
            5'd3: v = 32'd85004756;
            5'd4: v = 32'd42667331;
            5'd5: v = 32'd21354465;
            5'd6: v = 32'd10679838;
            5'd7: v = 32'd5340245;
            5'd8: v = 32'd2670163;
            5'd9: v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ src/rme_if.sv @@
interface rme_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] r00;
    logic signed [15:0] r10;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    modport source (output valid, r00, r10, r20, r21, r22, r11, r12, input ready);
    modport sink (input valid, r00, r10, r20, r21, r22, r11, r12, output ready);
endinterface

interface rme_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               is_singular;
    modport source (output valid, roll_angle, pitch_angle, yaw_angle, is_singular,
                    input ready);
    modport sink (input valid, roll_angle, pitch_angle, yaw_angle, is_singular,
                  output ready);
endinterface

@@ src/rme_isqrt.sv @@
module rme_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_val,
    output logic [15:0] o_root
);
    import rme_pkg::*;

    localparam int unsigned NS = 16;

    logic [31:0] r_v    [NS];
    logic [31:0] r_root [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_st
            logic [31:0] bit_k;
            logic [31:0] v_in;
            logic [31:0] root_in;
            logic [32:0] trial;
            logic [31:0] n_v;
            logic [31:0] n_root;

            assign bit_k = 32'd1 << (30 - 2 * k);
            if (k == 0) begin : g_first
                assign v_in    = i_val;
                assign root_in = '0;
            end else begin : g_rest
                assign v_in    = r_v[k-1];
                assign root_in = r_root[k-1];
            end

            always_comb begin
                trial = {1'b0, root_in} + {1'b0, bit_k};
                if ({1'b0, v_in} >= trial) begin
                    n_v    = v_in - trial[31:0];
                    n_root = (root_in >> 1) + bit_k;
                end else begin
                    n_v    = v_in;
                    n_root = root_in >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[k]    <= n_v;
                    r_root[k] <= n_root;
                end
            end
        end
    endgenerate

    assign o_root = r_root[NS-1][15:0];

endmodule

@@ src/rme_cordic.sv @@
module rme_cordic #(
    parameter int unsigned STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [16:0] i_y,
    input  logic signed [16:0] i_x,
    output logic [15:0]        o_angle
);
    import rme_pkg::*;

    localparam int unsigned NS = (STAGES < 32) ? STAGES : 32;

    logic signed [CW-1:0] r_x [NS+1];
    logic signed [CW-1:0] r_y [NS+1];
    logic [31:0]          r_z [NS+1];
    logic                 r_zero [NS+1];

    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic [31:0]          rnd;

    assign sx = {{(CW-33){i_x[16]}}, i_x, 16'd0};
    assign sy = {{(CW-33){i_y[16]}}, i_y, 16'd0};

    // quadrant fold so the vector starts in the right half plane
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (sx < 0) begin
                if (sy >= 0) begin
                    r_x[0] <= sy;
                    r_y[0] <= -sx;
                    r_z[0] <= ZQ_POS;
                end else begin
                    r_x[0] <= -sy;
                    r_y[0] <= sx;
                    r_z[0] <= ZQ_NEG;
                end
            end else begin
                r_x[0] <= sx;
                r_y[0] <= sy;
                r_z[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < NS; i++) begin : g_st
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_zero[i+1] <= r_zero[i];
                    if (r_y[i] >= 0) begin
                        r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                        r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                        r_z[i+1] <= r_z[i] + atan_lut(5'(i));
                    end else begin
                        r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                        r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                        r_z[i+1] <= r_z[i] - atan_lut(5'(i));
                    end
                end
            end
        end
    endgenerate

    assign rnd     = r_z[NS] + 32'h0000_8000;
    assign o_angle = r_zero[NS] ? 16'd0 : rnd[31:16];

endmodule

@@ src/rotation_matrix_to_euler_core.sv @@
// pipeline: squares, sum, square root, select, cordic fold and iterations, output register
// throughput: one beat per cycle; every stage advances together when the output
// register is empty or taken, so a stall holds the whole pipeline
// depth set by the 16-step square root and one stage per cordic iteration
// reset: synchronous active-low i_rst_n clears all valid bits, singular_limit to 1
module rotation_matrix_to_euler_core #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [14:0]     i_cfg_data,
    rme_in_if.sink          i_in,
    rme_out_if.source       o_out
);
    import rme_pkg::*;

    localparam int unsigned NS  = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
    localparam int unsigned SQD = 16;          // square root depth
    localparam int unsigned L   = NS + SQD + 5; // total stages incl. output register

    // pipeline advance: whole pipe moves when output slot frees up
    logic adv;
    logic r_vld [L];

    assign adv        = !r_vld[L-1] || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < L; j++) r_vld[j] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_in.valid;
            for (int j = 1; j < L; j++) r_vld[j] <= r_vld[j-1];
        end
    end

    // config register
    logic [14:0] r_limit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 15'd1;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // stage 1: squares of r00 and r10
    t_mat               in_mat;
    t_mat               r_mat0;
    logic signed [31:0] r_p0;
    logic signed [31:0] r_p1;

    assign in_mat = '{r00: i_in.r00, r10: i_in.r10, r20: i_in.r20, r21: i_in.r21,
                      r22: i_in.r22, r11: i_in.r11, r12: i_in.r12};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p0   <= i_in.r00 * i_in.r00;
            r_p1   <= i_in.r10 * i_in.r10;
            r_mat0 <= in_mat;
        end
    end

    // stage 2: sum of squares, at most 2^31
    logic [31:0] r_sq;
    t_mat        r_mat1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq   <= unsigned'(r_p0) + unsigned'(r_p1);
            r_mat1 <= r_mat0;
        end
    end

    // square root, one bit pair per stage; matrix rides alongside
    logic [15:0] sy;
    t_mat        r_matd [SQD];

    rme_isqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_val  (r_sq),
        .o_root (sy)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_matd[0] <= r_mat1;
            for (int j = 1; j < SQD; j++) r_matd[j] <= r_matd[j-1];
        end
    end

    // select stage: singular test and cordic operand choice
    t_mat               md;
    logic               sing;
    logic               r_sing;
    logic signed [16:0] r_roll_y, r_roll_x, r_pit_y, r_pit_x, r_yaw_y, r_yaw_x;

    assign md   = r_matd[SQD-1];
    assign sing = {1'b0, sy} < {2'b0, r_limit};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sing  <= sing;
            r_pit_y <= -17'(md.r20);
            r_pit_x <= {1'b0, sy};
            r_yaw_y <= 17'(md.r10);
            r_yaw_x <= 17'(md.r00);
            if (sing) begin
                r_roll_y <= -17'(md.r12);
                r_roll_x <= 17'(md.r11);
            end else begin
                r_roll_y <= 17'(md.r21);
                r_roll_x <= 17'(md.r22);
            end
        end
    end

    // three cordic pipelines in lockstep
    logic [15:0] roll_a, pit_a, yaw_a;

    rme_cordic #(.STAGES(NS)) u_roll (
        .i_clk(i_clk), .i_en(adv), .i_y(r_roll_y), .i_x(r_roll_x), .o_angle(roll_a)
    );
    rme_cordic #(.STAGES(NS)) u_pitch (
        .i_clk(i_clk), .i_en(adv), .i_y(r_pit_y), .i_x(r_pit_x), .o_angle(pit_a)
    );
    rme_cordic #(.STAGES(NS)) u_yaw (
        .i_clk(i_clk), .i_en(adv), .i_y(r_yaw_y), .i_x(r_yaw_x), .o_angle(yaw_a)
    );

    // singular flag delayed to match cordic latency
    logic r_singd [NS+1];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_singd[0] <= r_sing;
            for (int j = 1; j <= NS; j++) r_singd[j] <= r_singd[j-1];
        end
    end

    // output register
    logic [15:0] r_roll, r_pitch, r_yaw;
    logic        r_osing;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_roll  <= roll_a;
            r_pitch <= pit_a;
            r_yaw   <= r_singd[NS] ? 16'd0 : yaw_a;
            r_osing <= r_singd[NS];
        end
    end

    assign o_out.valid       = r_vld[L-1];
    assign o_out.roll_angle  = r_roll;
    assign o_out.pitch_angle = r_pitch;
    assign o_out.yaw_angle   = r_yaw;
    assign o_out.is_singular = r_osing;

    // checks
    a_sing_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_singular |-> o_out.yaw_angle == '0)
        else $error("yaw not zero on singular beat");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.roll_angle))
        else $error("stalled output beat changed");

endmodule
